/* rtl/assert_macros.svh */
// Assertion macros used by the RTL top level of the page eviction cache.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge, with no check while reset is high.
`define FPEC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define FPEC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/fpec_pkg.sv */
// Shared constants and types of the farthest page eviction cache.
package fpec_pkg;

  // Default geometry of the tag store.
  localparam int DEF_ENTRIES   = 8;
  localparam int DEF_PAGE_BITS = 16;

  // Fixed port widths of the page and occupancy fields.
  localparam int PAGE_PORT_W = 16;
  localparam int OCC_PORT_W  = 4;

  // Status of one scan over the tag store.
  typedef struct packed {
    logic hit;         // The requested page is held.
    logic free_found;  // At least one slot is empty.
    logic have_victim; // At least one held page was compared.
  } scan_flags_t;

endpackage

/* rtl/farthest_page_eviction_cache_top.sv */
// Top level of the farthest page eviction cache: sequencer, valid bits and result register.
//
//   Channel  Signals                                  Direction
//   input    in_valid, in_ready, mode, page_index     into the block
//   output   out_valid, out_ready, hit, evicted,      out of the block
//            evicted_page, occupancy
//
// An acquire reads all ENTRIES entries in turn through the single read port of the page
// RAM, waits in S_DRAIN for the last read to land, and then decides and writes back in
// S_FINISH. A flush goes straight from S_IDLE to S_FINISH.
// One item is in work at a time; a new item is taken once the previous one has reached
// the result register, even while that result still waits for out_ready.
// Reset clears all valid bits at once; page RAM contents are left as they are.
module farthest_page_eviction_cache_top #(
  parameter int ENTRIES   = fpec_pkg::DEF_ENTRIES,
  parameter int PAGE_BITS = fpec_pkg::DEF_PAGE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                mode,
  input  logic [fpec_pkg::PAGE_PORT_W-1:0]    page_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                hit,
  output logic                                evicted,
  output logic [fpec_pkg::PAGE_PORT_W-1:0]    evicted_page,
  output logic [fpec_pkg::OCC_PORT_W-1:0]     occupancy
);

`include "assert_macros.svh"

  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int PW      = (PAGE_BITS > fpec_pkg::PAGE_PORT_W) ? PAGE_BITS
                                                               : fpec_pkg::PAGE_PORT_W;
  localparam int OW      = (CNT_W > fpec_pkg::OCC_PORT_W) ? CNT_W : fpec_pkg::OCC_PORT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t                state, state_next;
  logic                  flush;
  logic [PAGE_BITS-1:0]  req_page;
  logic [IDX_W-1:0]      scan_idx;
  logic                  data_valid;
  logic [IDX_W-1:0]      data_idx;
  logic [ENTRIES-1:0]    valid_bits;
  logic [CNT_W-1:0]      held;
  logic [OW-1:0]         held_wide;
  logic [PW-1:0]         in_page_wide;
  logic [PW-1:0]         victim_wide;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic                  ram_re;
  logic [PAGE_BITS-1:0]  ram_rdata;

  fpec_pkg::scan_flags_t scan_flags;
  logic [IDX_W-1:0]      free_slot;
  logic [IDX_W-1:0]      victim_slot;
  logic [PAGE_BITS-1:0]  victim_page;

  logic                  in_xfer;
  logic                  slot_open;
  logic                  finish;

  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign slot_open = !out_valid || out_ready;
  assign finish    = (state == S_FINISH) && slot_open;

  // Page field masked or extended to the stored width.
  assign in_page_wide = PW'(page_index);
  assign victim_wide  = PW'(victim_page);
  assign held_wide    = OW'(held);
  assign occupancy    = held_wide[fpec_pkg::OCC_PORT_W-1:0];

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = mode ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_idx == LAST_IDX) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (slot_open) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture and read address counter.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      flush    <= mode;
      req_page <= in_page_wide[PAGE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      scan_idx <= '0;
    end else if (state == S_SCAN) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
  end

  // Read data tag: which entry arrives from the RAM in this cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
    end else begin
      data_valid <= (state == S_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    data_idx <= scan_idx;
  end

  // Page RAM access. Writes happen only after a scan is complete, so reads never overlap them.
  assign ram_re    = (state == S_SCAN);
  assign ram_we    = finish && !flush && !scan_flags.hit;
  assign ram_waddr = scan_flags.free_found ? free_slot : victim_slot;

  fpec_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req_page),
    .re    (ram_re),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  fpec_scan #(
    .PAGE_BITS (PAGE_BITS),
    .IDX_W     (IDX_W)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (in_xfer),
    .data_valid  (data_valid),
    .data_idx    (data_idx),
    .entry_live  (valid_bits[data_idx]),
    .entry_page  (ram_rdata),
    .req_page    (req_page),
    .flags       (scan_flags),
    .free_slot   (free_slot),
    .victim_slot (victim_slot),
    .victim_page (victim_page)
  );

  // Valid bits and the count of held pages.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      held       <= '0;
    end else if (finish) begin
      if (flush) begin
        valid_bits <= '0;
        held       <= '0;
      end else if (!scan_flags.hit && scan_flags.free_found) begin
        valid_bits[free_slot] <= 1'b1;
        held                  <= held + CNT_W'(1);
      end
    end
  end

  // Result register; the occupancy field follows the held count.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      hit          <= !flush && scan_flags.hit;
      evicted      <= !flush && !scan_flags.hit && !scan_flags.free_found;
      evicted_page <= (!flush && !scan_flags.hit && !scan_flags.free_found)
                      ? victim_wide[fpec_pkg::PAGE_PORT_W-1:0] : '0;
    end
  end

  // The held count never exceeds the store size.
  `FPEC_ASSERT(a_held_bound, clk, rst, held <= FULL_CNT, "held count exceeds entries")

  // The held count always matches the number of valid entries.
  `FPEC_ASSERT(a_held_matches, clk, rst, held == CNT_W'($countones(valid_bits)),
               "held count differs from valid bits")

  // An eviction only happens with a full store and never with a hit.
  `FPEC_ASSERT(a_evict_full, clk, rst,
               (finish && !flush && !scan_flags.hit && !scan_flags.free_found)
               |-> (held == FULL_CNT && scan_flags.have_victim),
               "eviction without a full store")

  // The page RAM is written only at the end of an acquire that missed.
  `FPEC_ASSERT(a_write_on_miss, clk, rst,
               ram_we |-> (state == S_FINISH && !flush && !scan_flags.hit),
               "page RAM written outside a miss")

endmodule

/* rtl/fpec_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module fpec_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered and enabled by re.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/fpec_scan.sv */
// Scan unit: looks at one stored entry per cycle for a hit, a free slot and the farthest page.
module fpec_scan #(
  parameter int PAGE_BITS = fpec_pkg::DEF_PAGE_BITS,
  parameter int IDX_W     = 3
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    data_valid,
  input  logic [IDX_W-1:0]        data_idx,
  input  logic                    entry_live,
  input  logic [PAGE_BITS-1:0]    entry_page,
  input  logic [PAGE_BITS-1:0]    req_page,
  output fpec_pkg::scan_flags_t   flags,
  output logic [IDX_W-1:0]        free_slot,
  output logic [IDX_W-1:0]        victim_slot,
  output logic [PAGE_BITS-1:0]    victim_page
);

  logic [PAGE_BITS-1:0] span;
  logic [PAGE_BITS-1:0] best_span;
  logic                 better;

  // Absolute distance between the stored page and the requested page.
  always_comb begin
    span = (entry_page > req_page) ? (entry_page - req_page) : (req_page - entry_page);
  end

  // A farther page wins; among equal distances the smaller page number wins.
  always_comb begin
    better = !flags.have_victim || (span > best_span) ||
             ((span == best_span) && (entry_page < victim_page));
  end

  // Scan flags are control state and clear at reset and at the start of each scan.
  always_ff @(posedge clk) begin
    if (rst || start) begin
      flags <= '0;
    end else if (data_valid) begin
      if (entry_live) begin
        if (entry_page == req_page) begin
          flags.hit <= 1'b1;
        end
        if (better) begin
          flags.have_victim <= 1'b1;
        end
      end else begin
        flags.free_found <= 1'b1;
      end
    end
  end

  // Slot numbers and the best candidate so far.
  always_ff @(posedge clk) begin
    if (data_valid) begin
      if (entry_live) begin
        if (better) begin
          best_span   <= span;
          victim_slot <= data_idx;
          victim_page <= entry_page;
        end
      end else if (!flags.free_found) begin
        free_slot <= data_idx;
      end
    end
  end

endmodule

/* dv/testbench.sv */
// Self-checking testbench of the farthest page eviction cache with random handshake stalls.
`timescale 1ns / 100ps

module testbench;

  localparam int PAGE_PORT_W = fpec_pkg::PAGE_PORT_W;
  localparam int OCC_PORT_W = fpec_pkg::OCC_PORT_W;
  localparam int NUM_ENTRIES = fpec_pkg::DEF_ENTRIES;
  // Wait after the last phase, long enough for an acquire, plus margin.
  localparam int SETTLE_CYCLES = NUM_ENTRIES + 2 + 12;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 275;

  typedef enum logic {
    MODE_ACQUIRE = 1'b0,
    MODE_FLUSH   = 1'b1
  } req_mode_t;

  typedef struct packed {
    logic                   hit;
    logic                   evicted;
    logic [PAGE_PORT_W-1:0] evicted_page;
    logic [OCC_PORT_W-1:0]  occupancy;
  } outcome_t;

  // Tracks the held pages and checks every result against the predicted outcome.
  class page_cache_scoreboard_t;
    logic [PAGE_PORT_W-1:0] held_page[NUM_ENTRIES];
    bit                     held_valid[NUM_ENTRIES];
    outcome_t               awaited_outcomes[$];
    int mismatches;
    int acquires;
    int hits;
    int evictions;
    int flushes;

    function new();
      foreach (held_valid[i]) begin
        held_valid[i] = 1'b0;
        held_page[i] = '0;
      end
      mismatches = 0;
      acquires = 0;
      hits = 0;
      evictions = 0;
      flushes = 0;
    endfunction

    function int pending();
      return awaited_outcomes.size();
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      mismatches++;
    endtask

    // Applies one request to the shadow store and returns the outcome it causes.
    function outcome_t predict_outcome(req_mode_t req, logic [PAGE_PORT_W-1:0] page);
      outcome_t o;
      int free_slot;
      int victim;
      int best;
      int span;
      int count;
      o = '0;
      free_slot = -1;
      victim = 0;
      best = -1;
      count = 0;
      if (req == MODE_FLUSH) begin
        foreach (held_valid[i]) held_valid[i] = 1'b0;
      end else begin
        foreach (held_valid[i]) begin
          if (held_valid[i]) begin
            if (held_page[i] == page) o.hit = 1'b1;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (!o.hit) begin
          if (free_slot >= 0) begin
            held_page[free_slot] = page;
            held_valid[free_slot] = 1'b1;
          end else begin
            // Store is full: evict the farthest page, the smaller one on a tie.
            foreach (held_page[i]) begin
              span = (held_page[i] > page) ? int'(held_page[i]) - int'(page)
                                           : int'(page) - int'(held_page[i]);
              if (span > best || (span == best && held_page[i] < held_page[victim])) begin
                best = span;
                victim = i;
              end
            end
            o.evicted = 1'b1;
            o.evicted_page = held_page[victim];
            held_page[victim] = page;
          end
        end
      end
      foreach (held_valid[i]) if (held_valid[i]) count++;
      o.occupancy = count[OCC_PORT_W-1:0];
      return o;
    endfunction

    // Notes an accepted request and queues the outcome it must produce.
    function void note_request(req_mode_t req, logic [PAGE_PORT_W-1:0] page);
      outcome_t o;
      o = predict_outcome(req, page);
      if (req == MODE_FLUSH) flushes++;
      else acquires++;
      if (o.hit) hits++;
      if (o.evicted) evictions++;
      awaited_outcomes.insert(awaited_outcomes.size(), o);
    endfunction

    // Compares one accepted result with the oldest predicted outcome.
    task check_outcome(outcome_t got);
      outcome_t want;
      if (awaited_outcomes.size() == 0) begin
        report_mismatch("result transfer with no request outstanding");
      end else begin
        want = awaited_outcomes[0];
        awaited_outcomes.delete(0);
        if (got.hit !== want.hit)
          report_mismatch($sformatf("hit %b, expected %b", got.hit, want.hit));
        if (got.evicted !== want.evicted)
          report_mismatch($sformatf("evicted %b, expected %b", got.evicted, want.evicted));
        if (got.evicted_page !== want.evicted_page)
          report_mismatch($sformatf("evicted_page %0d, expected %0d",
                                    got.evicted_page, want.evicted_page));
        if (got.occupancy !== want.occupancy)
          report_mismatch($sformatf("occupancy %0d, expected %0d",
                                    got.occupancy, want.occupancy));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   mode = MODE_ACQUIRE;
  logic [PAGE_PORT_W-1:0] page_index = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   hit;
  logic                   evicted;
  logic [PAGE_PORT_W-1:0] evicted_page;
  logic [OCC_PORT_W-1:0]  occupancy;

  page_cache_scoreboard_t sb = new();
  bit  calm_input = 1'b0;
  bit  calm_output = 1'b0;
  int  stall_left = 0;
  int  cycle_count = 0;
  logic [PAGE_PORT_W-1:0] window_base = '0;

  farthest_page_eviction_cache_top uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .page_index  (page_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .evicted     (evicted),
    .evicted_page(evicted_page),
    .occupancy   (occupancy)
  );

  always #5 clk = ~clk;

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Page choice: a narrow window around a base gives hits, fills and ties.
  function automatic logic [PAGE_PORT_W-1:0] pick_page();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return window_base + PAGE_PORT_W'($urandom_range(0, 15));
    if (r < 75) return window_base + PAGE_PORT_W'($urandom_range(0, 4000)) - 16'd2000;
    if (r < 95) return PAGE_PORT_W'($urandom);
    return (r < 97) ? '0 : '1;
  endfunction

  // Sends one request and waits for its transfer.
  task automatic send_request(req_mode_t req, logic [PAGE_PORT_W-1:0] page);
    int gap;
    gap = pick_gap(calm_input);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= req;
    page_index <= page;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req, page);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Result side: check each transfer and stall out_ready at random.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_outcome('{hit, evicted, evicted_page, occupancy});
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < 30) stall_left <= pick_gap(calm_output);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, sb.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty flush, page extremes, a hit, filling the store.
    send_request(MODE_FLUSH, 16'h0000);
    send_request(MODE_ACQUIRE, 16'h0000);
    send_request(MODE_ACQUIRE, 16'hFFFF);
    send_request(MODE_ACQUIRE, 16'h0000);
    for (int p = 100; p <= 600; p += 100) send_request(MODE_ACQUIRE, PAGE_PORT_W'(p));
    // Full store: evictions of the farthest page at both ends of the range.
    send_request(MODE_ACQUIRE, 16'd32768);
    send_request(MODE_ACQUIRE, 16'd350);
    // Two held pages equally far away: the smaller one goes.
    send_request(MODE_ACQUIRE, 16'd16434);
    // Hit on a full store, then a flush of a full store.
    send_request(MODE_ACQUIRE, 16'd300);
    send_request(MODE_FLUSH, 16'hFFFF);
    // Refill after the flush with alternating bit patterns.
    send_request(MODE_ACQUIRE, 16'd7);
    send_request(MODE_ACQUIRE, 16'd7);
    send_request(MODE_ACQUIRE, 16'hAAAA);
    send_request(MODE_ACQUIRE, 16'h5555);
    send_request(MODE_ACQUIRE, 16'hFFFF);
    send_request(MODE_FLUSH, 16'h1234);

    // Random phases; the sender holds off between phases until results catch up.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      calm_input = (ph == 1);
      calm_output = (ph == 1) || (ph == 4);
      case (ph % 3)
        0: window_base = PAGE_PORT_W'($urandom);
        1: window_base = '0;
        default: window_base = 16'hFFF0;
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 60 == 59) window_base = PAGE_PORT_W'($urandom);
        if ($urandom_range(0, 99) < 3) send_request(MODE_FLUSH, PAGE_PORT_W'($urandom));
        else send_request(MODE_ACQUIRE, pick_page());
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    // Let any stray result show up before closing.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    $display("Covered %0d acquires (%0d hits, %0d evictions) and %0d flushes.",
             sb.acquires, sb.hits, sb.evictions, sb.flushes);
    $display("Mismatches found: %0d.", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
